// ===== rtl/core/kps_pkg.sv =====
`timescale 1ns / 1ps

package kps_pkg;

    localparam int ROWS  = 4;
    localparam int COLS  = 4;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);

    localparam int DEB_W  = 16;
    localparam int CODE_W = 8;
    localparam int ROWL_W = 4;
    localparam int DRV_W  = 4;

    localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [1:0] REG_NO_KEY_CODE    = 2'd1;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd20;
    localparam logic [CODE_W-1:0] NO_KEY_RESET   = 8'd255;

    typedef enum logic [2:0] {
        PH_SCAN     = 3'b001,
        PH_WAIT     = 3'b010,
        PH_DEBOUNCE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              key_found;
        logic              scan_done;
        logic [DRV_W-1:0]  column_drive;
    } result_t;

    function automatic logic [CODE_W-1:0] key_lookup(input logic [1:0] row,
                                                     input logic [1:0] col);
        logic [CODE_W-1:0] code;
        unique case ({row, col})
            4'h0:    code = 8'h01;
            4'h1:    code = 8'h02;
            4'h2:    code = 8'h03;
            4'h3:    code = 8'h0A;
            4'h4:    code = 8'h04;
            4'h5:    code = 8'h05;
            4'h6:    code = 8'h06;
            4'h7:    code = 8'h2D;
            4'h8:    code = 8'h07;
            4'h9:    code = 8'h08;
            4'hA:    code = 8'h09;
            4'hB:    code = 8'h2B;
            4'hC:    code = 8'h23;
            4'hD:    code = 8'h00;
            4'hE:    code = 8'h2A;
            default: code = 8'h2F;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/kps_scan_ctrl.sv =====
`timescale 1ns / 1ps

module kps_scan_ctrl
    import kps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [ROWL_W-1:0] row_levels,
    input  logic [DEB_W-1:0]  debounce_ticks,
    input  logic [CODE_W-1:0] no_key_code,
    output result_t           result
);

    phase_t            phase_reg, phase_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [DEB_W-1:0]  count_reg, count_next;
    logic [CODE_W-1:0] held_key_reg, held_key_next;
    logic              held_valid_reg, held_valid_next;

    logic              released;
    logic              advance;
    logic              done;
    logic [DEB_W-1:0]  count_dec;
    logic [ROW_W-1:0]  row_adv;
    logic [COL_W-1:0]  col_adv;
    logic              pass_end;

    assign released  = (32'(row_reg) < ROWL_W) ? row_levels[row_reg] : 1'b1;
    assign count_dec = (count_reg != '0) ? count_reg - 1'b1 : '0;

    always_comb
    begin
        pass_end = 1'b0;
        col_adv  = col_reg;
        if (32'(row_reg) == ROWS - 1)
        begin
            row_adv = '0;
            if (32'(col_reg) == COLS - 1)
            begin
                col_adv  = '0;
                pass_end = 1'b1;
            end
            else
            begin
                col_adv = col_reg + 1'b1;
            end
        end
        else
        begin
            row_adv = row_reg + 1'b1;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        held_key_next   = held_key_reg;
        held_valid_next = held_valid_reg;
        advance         = 1'b0;
        unique case (phase_reg)
            PH_WAIT:
            begin
                if (released)
                begin
                    if (debounce_ticks == '0)
                    begin
                        advance = 1'b1;
                    end
                    else
                    begin
                        count_next = debounce_ticks;
                        phase_next = PH_DEBOUNCE;
                    end
                end
            end
            PH_DEBOUNCE:
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    advance = 1'b1;
                end
            end
            default:
            begin
                if (!released)
                begin
                    held_key_next   = key_lookup(2'(row_reg), 2'(col_reg));
                    held_valid_next = 1'b1;
                    phase_next      = PH_WAIT;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
        endcase
        row_next = row_reg;
        col_next = col_reg;
        if (advance)
        begin
            phase_next = PH_SCAN;
            row_next   = row_adv;
            col_next   = col_adv;
        end
        done = advance && pass_end;
        if (done)
        begin
            held_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result.column_drive = (32'(col_reg) < DRV_W) ?
                              ~(DRV_W'(1) << col_reg) : '1;
        result.scan_done    = done;
        result.key_found    = done && held_valid_reg;
        result.key_code     = !done ? '0 :
                              (held_valid_reg ? held_key_reg : no_key_code);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SCAN;
            row_reg        <= '0;
            col_reg        <= '0;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_key_reg <= held_key_next;
        end
    end

endmodule

// ===== rtl/core/kps_out_reg.sv =====
`timescale 1ns / 1ps

module kps_out_reg
    import kps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    m_tready,
    output logic    m_tvalid,
    output result_t data,
    output logic    space
);

    logic    valid_reg;
    result_t data_reg;

    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign data     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== rtl/core/matrix_keypad_scanner_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// s_axis    in   s_tdata: row_levels
// m_axis    out  m_tdata: column_drive, key_found, key_code; m_tlast: scan_done
// cfg       in   cfg_we/cfg_index/cfg_data: 0 debounce_ticks, 1 no_key_code
//
// One input beat per cycle unless stalled; its result beat appears in the next cycle.
// The single output register gates s_tready: a stall on m_tready stalls s_tready.
// Reset clears scan position, phase and latch; registers return to 20 and 255.

module matrix_keypad_scanner_core
    import kps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [3:0] row_levels
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [3:0] column_drive, [4] key_found, [12:5] key_code
    output logic              m_tlast,   // scan_done
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [DEB_W-1:0]  cfg_data
);

    logic [DEB_W-1:0]  debounce_ticks_reg;
    logic [CODE_W-1:0] no_key_code_reg;
    logic              accept;
    logic              space;
    result_t           step_result;
    result_t           out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
            no_key_code_reg    <= NO_KEY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data;
                REG_NO_KEY_CODE:    no_key_code_reg    <= cfg_data[CODE_W-1:0];
                default:            ;
            endcase
        end
    end

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    kps_scan_ctrl u_scan_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .row_levels     (s_tdata[ROWL_W-1:0]),
        .debounce_ticks (debounce_ticks_reg),
        .no_key_code    (no_key_code_reg),
        .result         (step_result)
    );

    kps_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (step_result),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .data      (out_data),
        .space     (space)
    );

    assign m_tdata = {3'b000, out_data.key_code, out_data.key_found, out_data.column_drive};
    assign m_tlast = out_data.scan_done;

endmodule
